// ===== design/fswg_pkg.sv =====
// Package for the four-shape waveform generator: sizes, codes, shared structs
// and the per-step coefficient table that all shapes are scaled by.
// No dependencies.
package fswg_pkg;

  // Steps per period and DAC resolution.
  localparam int unsigned STEPS       = 20;
  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned STEP_W      = $clog2(STEPS);

  // Field widths of the channels.
  localparam int unsigned DATA_W   = 16;
  localparam int unsigned IDX_W    = 2;
  localparam int unsigned COEF_W   = 32;
  localparam int unsigned PROD_W   = COEF_W + DATA_W;
  localparam int unsigned COEF_SH  = 31;

  localparam logic [DATA_W-1:0] FULL_SCALE =
    DATA_W'((64'd1 << SAMPLE_BITS) - 64'd1);

  // Q30 sine constants; one is 2^30 and pi/2 uses the true value of pi.
  localparam logic [63:0] Q_ONE       = 64'd1 << 30;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // Rounded-up reciprocal of STEPS in Q31, exact for floor(amp * n / STEPS).
  localparam logic [63:0] RECIP =
    ((64'd1 << COEF_SH) + 64'(STEPS) - 64'd1) / 64'(STEPS);

  typedef enum logic [1:0] {
    SHAPE_SINE   = 2'd0,
    SHAPE_SQUARE = 2'd1,
    SHAPE_SAW    = 2'd2,
    SHAPE_TRI    = 2'd3
  } fswg_shape_e;

  typedef enum logic [IDX_W-1:0] {
    REG_WAVE_SHAPE = 2'd0,
    REG_AMPLITUDE  = 2'd1,
    REG_OFFSET     = 2'd2,
    REG_HOLD_TICKS = 2'd3
  } fswg_reg_e;

  // Register file contents as seen by the datapath and the step sequencer.
  typedef struct packed {
    fswg_shape_e       wave_shape;
    logic [DATA_W-1:0] amplitude;
    logic [DATA_W-1:0] offset;
    logic [DATA_W-1:0] hold_ticks;
  } fswg_cfg_t;

  // One tick as handed from the step sequencer to the datapath.
  typedef struct packed {
    logic              emit;
    logic [STEP_W-1:0] step;
    logic              last;
  } fswg_tick_t;

  // Table indexed by shape, then by step.
  typedef logic [3:0][STEPS-1:0][COEF_W-1:0] fswg_coef_lut_t;

  // Next Taylor term magnitude before the divide by (2n)(2n+1).
  function automatic logic [63:0] taylor_next(input logic [63:0] term,
                                              input logic [63:0] x);
    logic [63:0] t;
    t = (term * x) >> 30;
    t = (t * x) >> 30;
    return t;
  endfunction

  // Subtract that floors at zero.
  function automatic logic [63:0] sub_floor(input logic [63:0] a,
                                            input logic [63:0] b);
    return (a >= b) ? (a - b) : 64'd0;
  endfunction

  // Sine of (pi/2)*r/STEPS in Q30 by Taylor series through x^15.
  function automatic logic [63:0] quarter_sine(input int unsigned r);
    logic [63:0] x;
    logic [63:0] term;
    logic [63:0] sum;
    x = (HALF_PI_Q30 * 64'(r)) / 64'(STEPS);
    term = x;
    sum  = x;
    term = taylor_next(term, x) / 64'd6;   sum = sub_floor(sum, term);
    term = taylor_next(term, x) / 64'd20;  sum = sum + term;
    term = taylor_next(term, x) / 64'd42;  sum = sub_floor(sum, term);
    term = taylor_next(term, x) / 64'd72;  sum = sum + term;
    term = taylor_next(term, x) / 64'd110; sum = sub_floor(sum, term);
    term = taylor_next(term, x) / 64'd156; sum = sum + term;
    term = taylor_next(term, x) / 64'd210; sum = sub_floor(sum, term);
    if (r == 0) begin
      sum = 64'd0;
    end else if (r >= STEPS) begin
      sum = Q_ONE;
    end else if (sum > Q_ONE) begin
      sum = Q_ONE;
    end
    return sum;
  endfunction

  // Q31 level (1 + sin) / 2 for step i.
  function automatic logic [COEF_W-1:0] sine_coef(input int unsigned i);
    int unsigned u;
    int unsigned quad;
    int unsigned r;
    logic [63:0] s;
    logic [63:0] v;
    u    = 4 * i;
    quad = (u / STEPS) % 4;
    r    = u % STEPS;
    s    = (quad % 2 == 1) ? quarter_sine(STEPS - r) : quarter_sine(r);
    v    = (quad >= 2) ? (Q_ONE - s) : (Q_ONE + s);
    return COEF_W'(v);
  endfunction

  // Coefficient table: shape value = (coef * amplitude) >> 31 for every shape.
  function automatic fswg_coef_lut_t build_coef_lut();
    fswg_coef_lut_t lut;
    lut = '0;
    for (int unsigned i = 0; i < STEPS; i++) begin
      lut[SHAPE_SINE][i]   = sine_coef(i);
      lut[SHAPE_SQUARE][i] = (2 * i <= STEPS) ? COEF_W'(64'd1 << COEF_SH) : '0;
      lut[SHAPE_SAW][i]    = COEF_W'(RECIP * 64'(i));
      lut[SHAPE_TRI][i]    = (2 * i <= STEPS) ? COEF_W'(RECIP * 64'(2 * i))
                                              : COEF_W'(RECIP * 64'(2 * STEPS - 2 * i));
    end
    return lut;
  endfunction

  localparam fswg_coef_lut_t COEF_LUT = build_coef_lut();

endpackage

// ===== design/fswg_if.sv =====
// Channel interfaces of the waveform generator: tick input, sample output and
// register write port. Depends on fswg_pkg.

// Tick channel: one beat per time tick.
interface fswg_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

// Sample channel: one beat per emitted DAC sample.
interface fswg_out_if;
  import fswg_pkg::*;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] sample;
  logic              period_end;

  modport source (output valid, output sample, output period_end, input ready);
  modport sink   (input valid, input sample, input period_end, output ready);
endinterface

// Register write channel.
interface fswg_cfg_if;
  import fswg_pkg::*;
  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  index;
  logic [DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/fswg_cfg_regs.sv =====
// Configuration register file of the waveform generator.
// Depends on fswg_pkg and fswg_cfg_if.
module fswg_cfg_regs (
  input  logic              clk_i,
  input  logic              rst_ni,
  fswg_cfg_if.sink          cfg_i,
  output fswg_pkg::fswg_cfg_t cfg_o
);
  import fswg_pkg::*;

  fswg_cfg_t cfg_q;

  // Writes are always taken.
  assign cfg_i.ready = 1'b1;

  // Register writes, decoded by index.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.wave_shape <= SHAPE_SINE;
      cfg_q.amplitude  <= '0;
      cfg_q.offset     <= '0;
      cfg_q.hold_ticks <= DATA_W'(1);
    end else if (cfg_i.valid) begin
      case (fswg_reg_e'(cfg_i.index))
        REG_WAVE_SHAPE: cfg_q.wave_shape <= fswg_shape_e'(cfg_i.data[1:0]);
        REG_AMPLITUDE:  cfg_q.amplitude  <= cfg_i.data;
        REG_OFFSET:     cfg_q.offset     <= cfg_i.data;
        REG_HOLD_TICKS: cfg_q.hold_ticks <= cfg_i.data;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== design/fswg_tick.sv =====
// Step sequencer: keeps the step index and hold counter and flags the first
// tick of each step. Depends on fswg_pkg.
module fswg_tick (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     accept_i,
  input  logic                     restart_i,
  input  logic [fswg_pkg::DATA_W-1:0] hold_ticks_i,
  output fswg_pkg::fswg_tick_t     tick_o
);
  import fswg_pkg::*;

  logic [STEP_W-1:0] step_q, step_d;
  logic [DATA_W-1:0] hold_q, hold_d;
  logic [STEP_W-1:0] step_cur;
  logic [DATA_W-1:0] hold_cur;
  logic [DATA_W-1:0] hold_eff;
  logic [DATA_W-1:0] hold_inc;
  logic              step_done;

  // A restart clears the position before this tick is used.
  assign step_cur = restart_i ? '0 : step_q;
  assign hold_cur = restart_i ? '0 : hold_q;
  assign hold_eff = (hold_ticks_i == '0) ? DATA_W'(1) : hold_ticks_i;
  assign hold_inc = hold_cur + DATA_W'(1);
  assign step_done = (hold_inc >= hold_eff) || (hold_inc == '0);

  // Advance the hold counter and wrap the step at the end of the period.
  always_comb begin
    hold_d = hold_inc;
    step_d = step_cur;
    if (step_done) begin
      hold_d = '0;
      step_d = (step_cur == STEP_W'(STEPS - 1)) ? '0 : step_cur + STEP_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      hold_q <= '0;
    end else if (accept_i) begin
      step_q <= step_d;
      hold_q <= hold_d;
    end
  end

  // Only the first tick of a step carries a sample.
  assign tick_o.emit = accept_i && (hold_cur == '0);
  assign tick_o.step = step_cur;
  assign tick_o.last = (step_cur == STEP_W'(STEPS - 1));

endmodule

// ===== design/fswg_dp.sv =====
// Sample datapath: step register, coefficient lookup and multiply, then offset
// add into the output register. Depends on fswg_pkg and fswg_out_if.
module fswg_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  fswg_pkg::fswg_cfg_t  cfg_i,
  input  fswg_pkg::fswg_tick_t tick_i,
  output logic                 ready_o,
  fswg_out_if.source           out_o
);
  import fswg_pkg::*;

  // Stage 1: accepted step.
  logic              s1_valid_q;
  logic [STEP_W-1:0] s1_step_q;
  logic              s1_last_q;
  // Stage 2: product and effective offset.
  logic              s2_valid_q;
  logic [PROD_W-1:0] s2_prod_q;
  logic [DATA_W-1:0] s2_off_q;
  logic              s2_last_q;
  // Output register.
  logic              out_valid_q;
  logic [DATA_W-1:0] out_sample_q;
  logic              out_last_q;

  logic              out_free;
  logic              s2_free;
  logic              s1_free;
  logic [DATA_W-1:0] amp_eff;
  logic [DATA_W:0]   amp_off_sum;
  logic [DATA_W-1:0] off_eff;
  logic [COEF_W-1:0] coef;
  logic [PROD_W-1:0] prod;
  logic [DATA_W-1:0] shape_val;
  logic [DATA_W:0]   sample_sum;

  // Each stage moves on when the one after it is empty or moving.
  assign out_free = !out_valid_q || out_o.ready;
  assign s2_free  = !s2_valid_q || out_free;
  assign s1_free  = !s1_valid_q || s2_free;
  assign ready_o  = s1_free;

  // Amplitude limit and offset clamp so the sum stays within full scale.
  assign amp_eff     = (cfg_i.amplitude > FULL_SCALE) ? FULL_SCALE : cfg_i.amplitude;
  assign amp_off_sum = {1'b0, amp_eff} + {1'b0, cfg_i.offset};
  assign off_eff     = (amp_off_sum > {1'b0, FULL_SCALE}) ? (FULL_SCALE - amp_eff)
                                                          : cfg_i.offset;

  // Shape coefficient times amplitude.
  assign coef = COEF_LUT[cfg_i.wave_shape][s1_step_q];
  assign prod = PROD_W'(coef) * PROD_W'(amp_eff);

  // Drop the Q31 fraction and add the offset.
  assign shape_val  = DATA_W'(s2_prod_q >> COEF_SH);
  assign sample_sum = {1'b0, shape_val} + {1'b0, s2_off_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_valid_q <= tick_i.emit;
      end
      if (s2_free) begin
        s2_valid_q <= s1_valid_q;
      end
      if (out_free) begin
        out_valid_q <= s2_valid_q;
      end
    end
  end

  // Payload registers, loaded whenever their stage is free.
  always_ff @(posedge clk_i) begin
    if (s1_free) begin
      s1_step_q <= tick_i.step;
      s1_last_q <= tick_i.last;
    end
    if (s2_free) begin
      s2_prod_q <= prod;
      s2_off_q  <= off_eff;
      s2_last_q <= s1_last_q;
    end
    if (out_free) begin
      out_sample_q <= sample_sum[DATA_W-1:0];
      out_last_q   <= s2_last_q;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.sample     = out_sample_q;
  assign out_o.period_end = out_last_q;

endmodule

// ===== design/four_shape_waveform_generator.sv =====
// Four-shape waveform generator (sine, square, sawtooth, triangle).
// Throughput: one tick beat per cycle unless the sample channel stalls; the sample
// for a tick that starts a step passes the step register, coefficient multiply and offset add.
// Ticks within a step give no sample. Reset clears step index and hold counter
// and loads the registers with sine, zero amplitude, zero offset, hold of one.
// Depends on fswg_pkg, fswg_if, fswg_cfg_regs, fswg_tick and fswg_dp.
module four_shape_waveform_generator (
  input  logic       clk_i,
  input  logic       rst_ni,
  fswg_cfg_if.sink   cfg_i,
  fswg_in_if.sink    in_i,
  fswg_out_if.source out_o
);
  import fswg_pkg::*;

  fswg_cfg_t  cfg;
  fswg_tick_t tick;
  logic       in_ready;
  logic       in_accept;

  // Tick beat handshake.
  assign in_i.ready = in_ready;
  assign in_accept  = in_i.valid && in_ready;

  fswg_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  fswg_tick u_tick (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (in_accept),
    .restart_i    (in_i.restart),
    .hold_ticks_i (cfg.hold_ticks),
    .tick_o       (tick)
  );

  fswg_dp u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .tick_i  (tick),
    .ready_o (in_ready),
    .out_o   (out_o)
  );

endmodule

// ===== sim/tb_four_shape_waveform_generator.sv =====
// Testbench for the four-shape waveform generator: drives tick and register
// beats, predicts every DAC sample and checks each one as it leaves the block.
// Depends on fswg_pkg, fswg_if and the design top four_shape_waveform_generator.
`timescale 1ns / 1ps

module tb_four_shape_waveform_generator;
  import fswg_pkg::*;

  localparam int unsigned RANDOM_TICKS   = 1130;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned LONG_STALL     = 200;
  localparam int unsigned STALL_PHASE    = 3;

  // One expected beat on the sample channel.
  typedef struct packed {
    logic [DATA_W-1:0] sample;
    logic              period_end;
  } dac_beat_t;

  // Tracks register contents and step position, and holds the samples still owed.
  class waveform_tracker;
    fswg_shape_e       wave_shape;
    logic [DATA_W-1:0] amplitude;
    logic [DATA_W-1:0] offset;
    logic [DATA_W-1:0] hold;
    int unsigned       step;
    logic [15:0]       hold_cnt;
    dac_beat_t         pending_samples[$];
    int unsigned       errors;
    int unsigned       compared;
    int unsigned       reg_writes;

    function new();
      wave_shape = SHAPE_SINE;
      amplitude  = '0;
      offset     = '0;
      hold       = 16'd1;
      step       = 0;
      hold_cnt   = '0;
      errors     = 0;
      compared   = 0;
      reg_writes = 0;
    endfunction

    function void write_reg(fswg_reg_e idx, logic [DATA_W-1:0] data);
      reg_writes++;
      case (idx)
        REG_WAVE_SHAPE: wave_shape = fswg_shape_e'(data[1:0]);
        REG_AMPLITUDE:  amplitude  = data;
        REG_OFFSET:     offset     = data;
        REG_HOLD_TICKS: hold       = data;
        default: ;
      endcase
    endfunction

    // Q30 sine of the quarter-wave angle (pi/2)*r/STEPS, Taylor series to x^15.
    function logic [63:0] quarter_wave_sin(int unsigned r);
      logic [63:0] x;
      logic [63:0] term;
      logic [63:0] sum;
      if (r == 0) return 64'd0;
      if (r >= STEPS) return Q_ONE;
      x = (HALF_PI_Q30 * 64'(r)) / 64'(STEPS);
      term = x;
      sum  = x;
      for (int unsigned n = 1; n <= 7; n++) begin
        term = ((((term * x) >> 30) * x) >> 30) / 64'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) begin
          sum = (sum >= term) ? sum - term : 64'd0;
        end else begin
          sum = sum + term;
        end
      end
      return (sum > Q_ONE) ? Q_ONE : sum;
    endfunction

    // Level above the offset for step i, between 0 and amp.
    function logic [63:0] shape_level(int unsigned i, logic [63:0] amp);
      int unsigned quad;
      int unsigned r;
      logic [63:0] s;
      logic [63:0] v;
      case (wave_shape)
        SHAPE_SINE: begin
          quad = ((4 * i) / STEPS) % 4;
          r    = (4 * i) % STEPS;
          s    = (quad % 2 == 1) ? quarter_wave_sin(STEPS - r) : quarter_wave_sin(r);
          v    = (quad >= 2) ? Q_ONE - s : Q_ONE + s;
          return (v * amp) >> 31;
        end
        SHAPE_SQUARE: return (2 * i <= STEPS) ? amp : 64'd0;
        SHAPE_SAW:    return (amp * 64'(i)) / 64'(STEPS);
        default: begin
          if (2 * i <= STEPS) return (amp * 64'(2 * i)) / 64'(STEPS);
          return (amp * 64'(2 * STEPS - 2 * i)) / 64'(STEPS);
        end
      endcase
    endfunction

    // Advance by one accepted tick; the first tick of a step owes a sample.
    function void note_tick(bit restart);
      logic [15:0] hold_eff;
      logic [63:0] amp;
      logic [63:0] off;
      dac_beat_t   beat;
      hold_eff = (hold == 0) ? 16'd1 : hold;
      if (restart) begin
        step     = 0;
        hold_cnt = '0;
      end
      if (step >= STEPS) step = 0;
      if (hold_cnt == 0) begin
        amp = (64'(amplitude) > 64'(FULL_SCALE)) ? 64'(FULL_SCALE) : 64'(amplitude);
        off = 64'(offset);
        // Clamp the offset so the peak still fits the DAC range.
        if (amp + off > 64'(FULL_SCALE)) off = 64'(FULL_SCALE) - amp;
        beat.sample     = DATA_W'(shape_level(step, amp) + off);
        beat.period_end = (step == STEPS - 1);
        pending_samples.push_back(beat);
      end
      hold_cnt = hold_cnt + 16'd1;
      if (hold_cnt >= hold_eff || hold_cnt == 0) begin
        hold_cnt = '0;
        step     = (step + 1 >= STEPS) ? 0 : step + 1;
      end
    endfunction

    function void check_sample(logic [DATA_W-1:0] sample, logic period_end);
      dac_beat_t want;
      if (pending_samples.size() == 0) begin
        errors++;
        $display("%0t: unexpected sample beat %h period_end %b", $time, sample, period_end);
        return;
      end
      want = pending_samples.pop_front();
      compared++;
      if (sample !== want.sample) begin
        errors++;
        $display("%0t: sample mismatch, expected %h, actual %h", $time, want.sample, sample);
      end
      if (period_end !== want.period_end) begin
        errors++;
        $display("%0t: period_end mismatch, expected %b, actual %b",
                 $time, want.period_end, period_end);
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  fswg_cfg_if cfg_ch ();
  fswg_in_if  in_ch ();
  fswg_out_if out_ch ();

  four_shape_waveform_generator dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_ch),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  waveform_tracker tracker;
  int unsigned     src_idle_pct;
  int unsigned     snk_idle_pct;
  bit              stall_request;
  int unsigned     ticks_sent;
  int unsigned     quiet_cycles;

  // Clock, 10 ns period.
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Send one tick beat after a random number of idle cycles.
  task automatic send_tick(bit restart);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_ch.valid   <= 1'b0;
      in_ch.restart <= 1'($urandom_range(0, 1));
      @(negedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.restart <= restart;
    do @(posedge clk_i); while (!in_ch.ready);
    tracker.note_tick(restart);
    ticks_sent++;
    @(negedge clk_i);
  endtask

  task automatic put_reg(fswg_reg_e idx, logic [DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk_i); while (!cfg_ch.ready);
    tracker.write_reg(idx, data);
    @(negedge clk_i);
  endtask

  // Stop ticks, wait out every owed sample and the pipeline tail.
  task automatic drain_samples();
    in_ch.valid <= 1'b0;
    while (tracker.pending_samples.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Write the registers selected by mask (bit 0 shape ... bit 3 hold) on an idle block.
  task automatic load_settings(fswg_shape_e shape, logic [DATA_W-1:0] amp,
                               logic [DATA_W-1:0] off, logic [DATA_W-1:0] hold,
                               logic [3:0] mask);
    drain_samples();
    if (mask[0]) put_reg(REG_WAVE_SHAPE, {14'($urandom), shape});
    if (mask[1]) put_reg(REG_AMPLITUDE, amp);
    if (mask[2]) put_reg(REG_OFFSET, off);
    if (mask[3]) put_reg(REG_HOLD_TICKS, hold);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [DATA_W-1:0] pick_level();
    case ($urandom_range(0, 5))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'($urandom_range(0, 255));
      default: return 16'($urandom);
    endcase
  endfunction

  // Receiver: random back-pressure, plus one long hold-off on request.
  always @(negedge clk_i) begin
    static int unsigned stall_left = 0;
    if (stall_request) begin
      stall_left    = LONG_STALL;
      stall_request = 1'b0;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end
  end

  // Compare every sample beat with the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      tracker.check_sample(out_ch.sample, out_ch.period_end);
    end
  end

  // Watchdog on cycles without any beat.
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog, no beat for %0d cycles", $time, quiet_cycles);
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int unsigned       rand_ticks;
    int unsigned       phases;
    int unsigned       n;
    bit                big_hold;
    logic [3:0]        mask;
    logic [DATA_W-1:0] hold;

    in_ch.valid   = 1'b0;
    in_ch.restart = 1'b0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.index  = REG_WAVE_SHAPE;
    cfg_ch.data   = '0;
    out_ch.ready  = 1'b0;
    rst_ni        = 1'b0;
    src_idle_pct  = 36;
    snk_idle_pct  = 53;
    stall_request = 1'b0;
    ticks_sent    = 0;
    quiet_cycles  = 0;
    rand_ticks    = 0;
    phases        = 0;
    tracker       = new();

    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset settings: sine with zero swing, one tick per step.
    repeat (3) send_tick(1'b0);

    // Full swing with full offset clamps the offset; zero hold acts as one.
    load_settings(SHAPE_SQUARE, 16'hFFFF, 16'hFFFF, 16'h0000, 4'hF);
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b1);

    // Triangle with an overflowing sum, then the hold is lowered mid-step.
    load_settings(SHAPE_TRI, 16'd40000, 16'd30000, 16'd3, 4'hF);
    repeat (5) send_tick(1'b0);
    load_settings(SHAPE_TRI, 16'd0, 16'd0, 16'd1, 4'b1000);
    repeat (3) send_tick(1'b0);

    // Smallest nonzero swing on the sawtooth, starting with a restart.
    load_settings(SHAPE_SAW, 16'd1, 16'd0, 16'd1, 4'hF);
    send_tick(1'b1);
    send_tick(1'b0);

    // Random settings, each followed by a burst of ticks.
    while (rand_ticks < RANDOM_TICKS) begin
      phases++;
      if (rand_ticks < RANDOM_TICKS / 3) begin
        src_idle_pct = 36;
        snk_idle_pct = 53;
      end else if (rand_ticks < 2 * RANDOM_TICKS / 3) begin
        src_idle_pct = 53;
        snk_idle_pct = 36;
      end else begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      mask     = (phases == 1) ? 4'hF : 4'($urandom);
      big_hold = ($urandom_range(0, 11) == 0);
      if (big_hold) begin
        hold = 16'($urandom_range(32768, 65535));
      end else if ($urandom_range(0, 5) == 0) begin
        hold = 16'($urandom_range(5, 30));
      end else begin
        hold = 16'($urandom_range(0, 4));
      end
      n = big_hold ? $urandom_range(3, 8) : $urandom_range(20, 60);
      // A very long hold left over from before is always replaced.
      if (big_hold || tracker.hold >= 16'd64) mask[3] = 1'b1;
      if (phases == STALL_PHASE) begin
        hold    = 16'd1;
        mask[3] = 1'b1;
        n       = 90;
      end
      load_settings(fswg_shape_e'($urandom_range(0, 3)), pick_level(), pick_level(),
                    hold, mask);
      if (phases == STALL_PHASE) stall_request = 1'b1;
      repeat (n) send_tick($urandom_range(0, 99) < 8);
      rand_ticks += n;
    end

    drain_samples();
    tracker.errors += tracker.pending_samples.size();

    $display("Run covered %0d ticks over %0d random settings and %0d register writes,",
             ticks_sent, phases, tracker.reg_writes);
    $display("with %0d samples compared and %0d errors.", tracker.compared, tracker.errors);
    if (tracker.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/fswg_pkg.sv
design/fswg_if.sv
design/fswg_cfg_regs.sv
design/fswg_tick.sv
design/fswg_dp.sv
design/four_shape_waveform_generator.sv
sim/tb_four_shape_waveform_generator.sv
